/* rtl/ppfa_pkg.sv */
// Package for the paired packet frame assembler.
// Holds packet geometry constants and the controller/datapath command and status types.
// Used by the controller, the datapath, the core and the bench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ppfa_pkg;

  localparam int FRAMES_DEF    = 8;    // frame slots in the ring
  localparam int SAMPLE_W      = 16;
  localparam int POINT_W       = 8;
  localparam int POS_W         = 10;   // word position within a packet
  localparam int GRP_W         = 7;    // sample group counter
  localparam int SUB_W         = 3;    // word within a group
  localparam int PACKET_WORDS  = 733;
  localparam int GROUP_WORDS   = 6;    // x, y, z, two of each
  localparam int BANKS         = 6;    // one bank per channel and sample parity
  localparam int BANK_ROWS     = 244;  // rows per slot in each bank
  localparam int HALF_ROWS     = 122;  // rows written by one packet
  localparam int PAD_POINTS    = 6;    // leading points that read as zero
  localparam int LAST_DATA_PT  = 249;  // last point that holds samples
  localparam int LAST_POINT    = 255;  // reading it releases the frame

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic clr_en;    // clear one slot number entry
    logic word_en;   // packet word transfer
    logic read_en;   // read request transfer
    logic load_out;  // move read data into the output register
  } ppfa_cmd_t;

  typedef struct packed {
    logic clr_last;  // clearing pass at its last entry
    logic out_free;  // output register empty or being taken
  } ppfa_sts_t;

endpackage

`default_nettype wire

/* rtl/ppfa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the sample banks and the slot number table; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ppfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/ppfa_ctrl.sv */
// Controller state machine: clearing pass, input handshake and output load sequencing.
// Depends on ppfa_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none

module ppfa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic                in_kind,
  output logic                     in_tready,
  input  wire ppfa_pkg::ppfa_sts_t sts,
  output ppfa_pkg::ppfa_cmd_t      cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign accept = in_tvalid & in_tready;

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.clr_en   = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (accept && in_kind) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        // RAM data is ready; once the output register is free, hand it over and take the next item in the same cycle
        in_tready    = sts.out_free;
        cmd.load_out = sts.out_free;
        if (sts.out_free && !(accept && in_kind)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
    cmd.word_en = accept & ~in_kind;
    cmd.read_en = accept & in_kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/ppfa_dp.sv */
// Datapath: packet word counters, slot ring pointers, sample banks, slot number table
// and the output register. Depends on ppfa_pkg and ppfa_ram.
`timescale 1ns / 1ps
`default_nettype none

module ppfa_dp #(
  parameter int FRAMES = ppfa_pkg::FRAMES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire ppfa_pkg::ppfa_cmd_t                   cmd,
  output ppfa_pkg::ppfa_sts_t                        sts,
  input  wire ppfa_pkg::sample_t                     in_word,
  input  wire logic [ppfa_pkg::POINT_W-1:0]          in_point,
  input  wire logic                                  out_tready,
  output logic                                       out_tvalid,
  output logic                                       out_valid_res,
  output ppfa_pkg::sample_t                          out_smp [ppfa_pkg::BANKS]
);

  localparam int SW = $clog2(FRAMES);
  localparam int AW = $clog2(FRAMES * ppfa_pkg::BANK_ROWS);

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    next_slot = (s == SW'(FRAMES - 1)) ? '0 : s + 1'b1;
  endfunction

  logic [SW-1:0]                 write_slot_r, write_slot_nxt;
  logic [SW-1:0]                 read_slot_r, read_slot_nxt;
  logic [SW-1:0]                 clr_cnt_r;
  logic [ppfa_pkg::POS_W-1:0]    word_pos_r, word_pos_nxt;
  logic [ppfa_pkg::GRP_W-1:0]    grp_r, grp_nxt;
  logic [ppfa_pkg::SUB_W-1:0]    sub_r, sub_nxt;
  logic [ppfa_pkg::SAMPLE_W-1:0] pkt_num_r, pkt_num_nxt;
  logic                          drop_r, drop_nxt;
  logic                          rd_valid_r, rd_pad_r;
  logic                          out_valid_r;
  logic                          out_res_r;
  ppfa_pkg::sample_t             out_smp_r [ppfa_pkg::BANKS];

  logic                          smp_wr;
  logic [AW-1:0]                 smp_wr_addr, smp_rd_addr;
  logic [ppfa_pkg::SAMPLE_W-1:0] bank_q [ppfa_pkg::BANKS];

  logic                          slot_wr;
  logic [SW-1:0]                 slot_wr_addr;
  logic [ppfa_pkg::SAMPLE_W-1:0] slot_wr_data, slot_q;

  logic                          first_word, last_word, complete;
  logic signed [ppfa_pkg::SAMPLE_W:0] slot_inc, pkt_ext;

  assign first_word = (word_pos_r == '0);
  assign last_word  = (word_pos_r == ppfa_pkg::POS_W'(ppfa_pkg::PACKET_WORDS - 1));
  assign slot_inc   = $signed({slot_q[ppfa_pkg::SAMPLE_W-1], slot_q})
                    + $signed({{ppfa_pkg::SAMPLE_W{1'b0}}, 1'b1});
  assign pkt_ext    = $signed({pkt_num_r[ppfa_pkg::SAMPLE_W-1], pkt_num_r});
  assign complete   = pkt_num_r[0] && (slot_inc == pkt_ext);

  assign smp_wr      = cmd.word_en && !first_word && !drop_r;
  assign smp_wr_addr = AW'(write_slot_r) * AW'(ppfa_pkg::BANK_ROWS)
                     + (pkt_num_r[0] ? AW'(ppfa_pkg::HALF_ROWS) : AW'(0))
                     + AW'(grp_r);
  assign smp_rd_addr = AW'(read_slot_r) * AW'(ppfa_pkg::BANK_ROWS)
                     + AW'(in_point) - AW'(ppfa_pkg::PAD_POINTS);

  // Packet word sequencing, slot number table writes and the slot ring
  always_comb begin
    write_slot_nxt = write_slot_r;
    read_slot_nxt  = read_slot_r;
    word_pos_nxt   = word_pos_r;
    grp_nxt        = grp_r;
    sub_nxt        = sub_r;
    pkt_num_nxt    = pkt_num_r;
    drop_nxt       = drop_r;
    slot_wr        = 1'b0;
    slot_wr_addr   = write_slot_r;
    slot_wr_data   = pkt_num_r;
    if (cmd.clr_en) begin
      slot_wr      = 1'b1;
      slot_wr_addr = clr_cnt_r;
      slot_wr_data = '0;
    end
    if (cmd.word_en) begin
      if (first_word) begin
        pkt_num_nxt = in_word;
        drop_nxt    = (read_slot_r == next_slot(write_slot_r));
        grp_nxt     = '0;
        sub_nxt     = '0;
      end else if (sub_r == ppfa_pkg::SUB_W'(ppfa_pkg::GROUP_WORDS - 1)) begin
        sub_nxt = '0;
        grp_nxt = grp_r + 1'b1;
      end else begin
        sub_nxt = sub_r + 1'b1;
      end
      if (last_word && !drop_r) begin
        if (complete) begin
          write_slot_nxt = next_slot(write_slot_r);
        end else begin
          slot_wr = 1'b1;
        end
      end
      word_pos_nxt = last_word ? '0 : word_pos_r + 1'b1;
    end
    if (cmd.read_en && (read_slot_r != write_slot_r) &&
        (in_point == ppfa_pkg::POINT_W'(ppfa_pkg::LAST_POINT))) begin
      read_slot_nxt = next_slot(read_slot_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r <= '0;
      read_slot_r  <= '0;
      clr_cnt_r    <= '0;
      word_pos_r   <= '0;
      grp_r        <= '0;
      sub_r        <= '0;
      pkt_num_r    <= '0;
      drop_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      write_slot_r <= write_slot_nxt;
      read_slot_r  <= read_slot_nxt;
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      word_pos_r   <= word_pos_nxt;
      grp_r        <= grp_nxt;
      sub_r        <= sub_nxt;
      pkt_num_r    <= pkt_num_nxt;
      drop_r       <= drop_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Read request side info travels alongside the RAM read
  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      rd_valid_r <= (read_slot_r != write_slot_r);
      rd_pad_r   <= (in_point < ppfa_pkg::POINT_W'(ppfa_pkg::PAD_POINTS)) ||
                    (in_point > ppfa_pkg::POINT_W'(ppfa_pkg::LAST_DATA_PT));
    end
    if (cmd.load_out) begin
      out_res_r <= rd_valid_r;
      for (int b = 0; b < ppfa_pkg::BANKS; b++) begin
        out_smp_r[b] <= (rd_valid_r && !rd_pad_r) ? $signed(bank_q[b]) : '0;
      end
    end
  end

  // One bank per channel and sample parity, in result field order
  for (genvar b = 0; b < ppfa_pkg::BANKS; b++) begin : g_bank
    ppfa_ram #(
      .WIDTH (ppfa_pkg::SAMPLE_W),
      .DEPTH (FRAMES * ppfa_pkg::BANK_ROWS)
    ) u_bank (
      .clk     (clk),
      .wr_en   (smp_wr && (sub_r == ppfa_pkg::SUB_W'(b))),
      .wr_addr (smp_wr_addr),
      .wr_data (in_word),
      .rd_en   (cmd.read_en),
      .rd_addr (smp_rd_addr),
      .rd_data (bank_q[b])
    );
  end

  // Slot number table, read continuously at the write slot
  ppfa_ram #(
    .WIDTH (ppfa_pkg::SAMPLE_W),
    .DEPTH (FRAMES)
  ) u_slot_num (
    .clk     (clk),
    .wr_en   (slot_wr),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_data),
    .rd_en   (1'b1),
    .rd_addr (write_slot_r),
    .rd_data (slot_q)
  );

  assign sts.clr_last   = (clr_cnt_r == SW'(FRAMES - 1));
  assign sts.out_free   = !out_valid_r || out_tready;
  assign out_tvalid     = out_valid_r;
  assign out_valid_res  = out_res_r;
  assign out_smp        = out_smp_r;

endmodule

`default_nettype wire

/* rtl/paired_packet_frame_assembler_core.sv */
// Paired packet frame assembler: a read result passes through the registered sample bank
// read and then the output register before it appears on out_*.
// Throughput is one item per cycle while the output register drains; a stalled output
// holds the next read in the bank read stage and stops further input transfers.
// Synchronous reset, then a clearing pass over every slot number table entry, during
// which in_tready stays low.
`timescale 1ns / 1ps
`default_nettype none

module paired_packet_frame_assembler_core #(
  parameter int FRAMES = ppfa_pkg::FRAMES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [15:0] word, [23:16] point
  input  wire logic        in_tuser,   // [0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // x_real, x_imag, y_real, y_imag, z_real, z_imag
  output logic             out_tuser   // [0] valid_res
);

  ppfa_pkg::ppfa_cmd_t cmd;
  ppfa_pkg::ppfa_sts_t sts;
  ppfa_pkg::sample_t   out_smp [ppfa_pkg::BANKS];

  ppfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ppfa_dp #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_word       ($signed(in_tdata[15:0])),
    .in_point      (in_tdata[23:16]),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_valid_res (out_tuser),
    .out_smp       (out_smp)
  );

  always_comb begin
    for (int b = 0; b < ppfa_pkg::BANKS; b++) begin
      out_tdata[b*ppfa_pkg::SAMPLE_W +: ppfa_pkg::SAMPLE_W] = out_smp[b];
    end
  end

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking bench for paired_packet_frame_assembler_core: packet words and point reads
// go in on the in_* stream, complex point pairs come back on out_* against a local predictor.
// Depends on ppfa_pkg and the core only.
`timescale 1ns / 1ps

module tb;

  localparam int       FRAMES      = ppfa_pkg::FRAMES_DEF;
  localparam logic     KIND_WORD   = 1'b0;
  localparam logic     KIND_READ   = 1'b1;
  localparam int       FIRST_POS   = 2 * ppfa_pkg::PAD_POINTS;           // first stored sample
  localparam int       CH_POS      = 2 * (ppfa_pkg::LAST_DATA_PT + 1) - FIRST_POS;
  localparam int       HALF_POS    = CH_POS / 2;                         // samples per packet
  localparam int       CYCLE_LIMIT = 1_000_000;

  typedef enum logic [1:0] {ROW_PACKET, ROW_PAIRS, ROW_READ} row_kind_t;
  typedef enum logic {FILL_RANDOM, FILL_EXTREME} fill_t;

  // num is the packet number, the pair count or the point, by kind
  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] num;
    fill_t       fill;
    logic        fixed_exp;
    logic        fixed_vld;
  } dir_row_t;

  typedef struct packed {
    logic                                vld;
    logic [5:0][ppfa_pkg::SAMPLE_W-1:0]  smp;  // x_real, x_imag, y_real, y_imag, z_real, z_imag
  } point_pair_t;

  localparam int DIR_N = 28;
  localparam dir_row_t DIR_ROWS [0:DIR_N-1] = '{
    '{ROW_READ,   16'd0,     FILL_RANDOM,  1'b1, 1'b0},  // empty ring after reset
    '{ROW_READ,   16'd255,   FILL_RANDOM,  1'b1, 1'b0},  // release on empty ring is a no-op
    '{ROW_PACKET, 16'd4,     FILL_EXTREME, 1'b0, 1'b0},
    '{ROW_PACKET, 16'd5,     FILL_RANDOM,  1'b0, 1'b0},  // completes slot 0
    '{ROW_READ,   16'd0,     FILL_RANDOM,  1'b1, 1'b1},  // leading padding
    '{ROW_READ,   16'd5,     FILL_RANDOM,  1'b1, 1'b1},
    '{ROW_READ,   16'd6,     FILL_RANDOM,  1'b0, 1'b0},
    '{ROW_READ,   16'd127,   FILL_RANDOM,  1'b0, 1'b0},
    '{ROW_READ,   16'd128,   FILL_RANDOM,  1'b0, 1'b0},
    '{ROW_READ,   16'd249,   FILL_RANDOM,  1'b0, 1'b0},
    '{ROW_READ,   16'd250,   FILL_RANDOM,  1'b1, 1'b1},  // trailing padding
    '{ROW_READ,   16'd255,   FILL_RANDOM,  1'b1, 1'b1},  // pop the frame
    '{ROW_READ,   16'd10,    FILL_RANDOM,  1'b1, 1'b0},  // empty again
    '{ROW_PACKET, 16'hFFFE,  FILL_RANDOM,  1'b0, 1'b0},  // -2, -1: negative odd number
    '{ROW_PACKET, 16'hFFFF,  FILL_RANDOM,  1'b0, 1'b0},
    '{ROW_PACKET, 16'h7FFE,  FILL_EXTREME, 1'b0, 1'b0},
    '{ROW_PACKET, 16'h7FFF,  FILL_RANDOM,  1'b0, 1'b0},
    '{ROW_PACKET, 16'h8000,  FILL_RANDOM,  1'b0, 1'b0},  // -32768, -32767
    '{ROW_PACKET, 16'h8001,  FILL_RANDOM,  1'b0, 1'b0},
    '{ROW_PACKET, 16'd7,     FILL_RANDOM,  1'b0, 1'b0},  // odd without match: number kept
    '{ROW_PACKET, 16'd8,     FILL_RANDOM,  1'b0, 1'b0},
    '{ROW_PAIRS,  16'd4,     FILL_RANDOM,  1'b0, 1'b0},  // fill the ring
    '{ROW_PACKET, 16'd10,    FILL_RANDOM,  1'b0, 1'b0},  // dropped while full
    '{ROW_PACKET, 16'd11,    FILL_RANDOM,  1'b0, 1'b0},
    '{ROW_READ,   16'd6,     FILL_RANDOM,  1'b0, 1'b0},
    '{ROW_READ,   16'd255,   FILL_RANDOM,  1'b1, 1'b1},
    '{ROW_PACKET, 16'd12,    FILL_RANDOM,  1'b0, 1'b0},  // room again: completes
    '{ROW_PACKET, 16'd13,    FILL_RANDOM,  1'b0, 1'b0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [15:0] word, [23:16] point
  logic        in_tuser;   // [0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;  // x_real, x_imag, y_real, y_imag, z_real, z_imag
  logic        out_tuser;  // [0] valid_res

  bit          quiet;
  int          mismatch_count;
  int          reads_sent;
  point_pair_t expected_points [$];
  string       smp_name [6] = '{"x_real", "x_imag", "y_real", "y_imag", "z_real", "z_imag"};

  // predictor state
  ppfa_pkg::sample_t frame_mem   [FRAMES][3][CH_POS];
  bit                pos_written [FRAMES][3][CH_POS];
  logic [15:0]       slot_num    [FRAMES];
  int                wr_slot, rd_slot, word_pos;
  logic [15:0]       pkt_num;
  bit                drop_pkt;

  paired_packet_frame_assembler_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int ring_next(input int s);
    return (s + 1 >= FRAMES) ? 0 : s + 1;
  endfunction

  task automatic absorb_word(input logic [15:0] w);
    int k, ch, off, sn, pn;
    if (word_pos == 0) begin
      pkt_num  = w;
      drop_pkt = (rd_slot == ring_next(wr_slot));
    end else if (!drop_pkt) begin
      k   = word_pos - 1;
      ch  = (k % ppfa_pkg::GROUP_WORDS) / 2;
      off = (pkt_num[0] ? HALF_POS : 0) + (k / ppfa_pkg::GROUP_WORDS) * 2 + (k % 2);
      frame_mem[wr_slot][ch][off]   = w;
      pos_written[wr_slot][ch][off] = 1'b1;
    end
    if (word_pos == ppfa_pkg::PACKET_WORDS - 1 && !drop_pkt) begin
      sn = $signed(slot_num[wr_slot]);
      pn = $signed(pkt_num);
      // compare without wrap: an odd number one above the stored one closes the frame
      if (pkt_num[0] && sn + 1 == pn) wr_slot = ring_next(wr_slot);
      else slot_num[wr_slot] = pkt_num;
    end
    word_pos = (word_pos + 1 >= ppfa_pkg::PACKET_WORDS) ? 0 : word_pos + 1;
  endtask

  task automatic predict_read(input logic [7:0] pt, output point_pair_t r);
    int n;
    r = '0;
    if (rd_slot != wr_slot) begin
      r.vld = 1'b1;
      for (int s = 0; s < 2; s++) begin
        n = int'(pt) * 2 + s;
        if (n >= FIRST_POS && n < FIRST_POS + CH_POS)
          for (int ch = 0; ch < 3; ch++) r.smp[ch * 2 + s] = frame_mem[rd_slot][ch][n - FIRST_POS];
      end
      if (pt == ppfa_pkg::LAST_POINT) rd_slot = ring_next(rd_slot);
    end
  endtask

  // true unless the read would touch a sample never written since reset
  function automatic bit point_ready(input logic [7:0] pt);
    int n;
    if (rd_slot == wr_slot) return 1'b1;
    for (int s = 0; s < 2; s++) begin
      n = int'(pt) * 2 + s;
      if (n >= FIRST_POS && n < FIRST_POS + CH_POS)
        for (int ch = 0; ch < 3; ch++)
          if (!pos_written[rd_slot][ch][n - FIRST_POS]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // called at a falling edge, returns at a falling edge after the transfer
  task automatic send_item(input logic kind, input logic [15:0] w, input logic [7:0] pt,
                           input bit fixed_exp = 1'b0, input logic fixed_vld = 1'b0);
    point_pair_t r;
    while (!quiet && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {pt, w};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == KIND_READ) begin
      predict_read(pt, r);
      if (fixed_exp) begin
        r.vld = fixed_vld;
        r.smp = '0;
      end
      expected_points.push_back(r);
      reads_sent++;
    end else begin
      absorb_word(w);
    end
    @(negedge clk);
  endtask

  task automatic issue_read();
    logic [7:0] pt;
    case ($urandom_range(19))
      0:       pt = 8'(ppfa_pkg::LAST_POINT);
      1:       pt = 8'($urandom_range(ppfa_pkg::PAD_POINTS - 1, 0));
      2:       pt = 8'($urandom_range(ppfa_pkg::LAST_POINT - 1, ppfa_pkg::LAST_DATA_PT + 1));
      default: pt = 8'($urandom_range(ppfa_pkg::LAST_DATA_PT, ppfa_pkg::PAD_POINTS));
    endcase
    if (!point_ready(pt)) pt = 8'($urandom_range(ppfa_pkg::PAD_POINTS - 1, 0));
    send_item(KIND_READ, 16'($urandom), pt);
  endtask

  task automatic send_packet(input logic [15:0] num, input fill_t fill, input bit mix_reads);
    logic [15:0] w;
    // finish a packet that was cut short so this one starts aligned
    while (word_pos != 0) send_item(KIND_WORD, 16'($urandom), 8'($urandom));
    send_item(KIND_WORD, num, 8'($urandom));
    for (int i = 1; i < ppfa_pkg::PACKET_WORDS; i++) begin
      if (mix_reads && $urandom_range(49) == 0) issue_read();
      if (fill == FILL_EXTREME) w = i[0] ? 16'h7FFF : 16'h8000;
      else w = 16'($urandom);
      send_item(KIND_WORD, w, 8'($urandom));
    end
  endtask

  task automatic send_pair(input bit mix_reads);
    logic [15:0] n;
    n = 16'($urandom);
    n[0] = 1'b0;
    send_packet(n, FILL_RANDOM, mix_reads);
    send_packet(n | 16'd1, FILL_RANDOM, mix_reads);
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= quiet || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin : check_points
    point_pair_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_points.size() == 0) begin
        flag_mismatch("result transfer with nothing expected");
      end else begin
        exp_r = expected_points.pop_front();
        if (out_tuser !== exp_r.vld)
          flag_mismatch($sformatf("valid_res got %b want %b", out_tuser, exp_r.vld));
        for (int i = 0; i < 6; i++)
          if (out_tdata[16*i +: 16] !== exp_r.smp[i])
            flag_mismatch($sformatf("%s got %0d want %0d", smp_name[i],
                                    $signed(out_tdata[16*i +: 16]), $signed(exp_r.smp[i])));
      end
    end
  end

  initial begin
    int ep;
    int pick;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = KIND_WORD;
    quiet          = 1'b0;
    mismatch_count = 0;
    reads_sent     = 0;
    wr_slot        = 0;
    rd_slot        = 0;
    word_pos       = 0;
    pkt_num        = '0;
    drop_pkt       = 1'b0;
    foreach (slot_num[i]) slot_num[i] = '0;
    foreach (pos_written[i, j, k]) pos_written[i][j][k] = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      case (DIR_ROWS[i].kind)
        ROW_PACKET: send_packet(DIR_ROWS[i].num, DIR_ROWS[i].fill, 1'b0);
        ROW_PAIRS:  repeat (DIR_ROWS[i].num) send_pair(1'b0);
        default:    send_item(KIND_READ, 16'($urandom), DIR_ROWS[i].num[7:0],
                              DIR_ROWS[i].fixed_exp, DIR_ROWS[i].fixed_vld);
      endcase
    end

    // random part: matched pairs most often, some lone and cut packets, read bursts between
    ep = 0;
    while (ep < 30 || reads_sent < 500) begin
      quiet = (ep >= 10 && ep < 18);
      pick  = $urandom_range(99);
      if (pick < 45) send_pair(1'b1);
      else if (pick < 55) send_packet(16'($urandom), FILL_RANDOM, 1'b1);
      else if (pick < 60) repeat ($urandom_range(ppfa_pkg::PACKET_WORDS - 1, 1))
        send_item(KIND_WORD, 16'($urandom), 8'($urandom));
      else repeat ($urandom_range(30, 1)) issue_read();
      ep++;
    end
    quiet = 1'b0;

    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
